FILE: sv/sssf_pkg.sv
// Shared types, constants and segment table for the seven-segment scan formatter.
`timescale 1ns / 1ps

package sssf_pkg;

  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned POS_W = $clog2(NUM_DIGITS);

  localparam logic [16:0] ANGLE_MAX = 17'd99999;
  localparam logic [9:0]  TEMP_MAX  = 10'd999;
  localparam logic [3:0]  GLYPH_DEGREE = 4'd10;

  // floor(x / d) = (x * k) >> s, exact for x below 2^17
  localparam logic [17:0] RECIP_10  = 18'd209716;
  localparam logic [17:0] RECIP_100 = 18'd167773;
  localparam logic [17:0] RECIP_1K  = 18'd134218;
  localparam logic [17:0] RECIP_10K = 18'd107375;
  localparam logic [4:0]  SHIFT_10  = 5'd21;
  localparam logic [4:0]  SHIFT_100 = 5'd24;
  localparam logic [4:0]  SHIFT_1K  = 5'd27;
  localparam logic [4:0]  SHIFT_10K = 5'd30;

  typedef enum logic [2:0] {
    DIV_1,
    DIV_10,
    DIV_100,
    DIV_1K,
    DIV_10K
  } div_sel_t;

  typedef struct packed {
    logic             mode;
    logic             show;
    logic [POS_W-1:0] pos;
  } ctl_t;

  typedef struct packed {
    logic [16:0] quot;
    logic        dp;
    logic        degree;
  } scaled_t;

  function automatic logic [6:0] seg_code(input logic [3:0] glyph);
    logic [6:0] seg;
    case (glyph)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      4'd10:   seg = 7'h63;
      default: seg = 7'h3F;
    endcase
    return seg;
  endfunction

endpackage

FILE: sv/sssf_scale.sv
// Magnitude, range selection and scaling of the value behind the current digit.
`timescale 1ns / 1ps

module sssf_scale
  import sssf_pkg::*;
(
  input  logic        [17:0] angle_centi,
  input  logic        [14:0] temp_deci,
  input  ctl_t               ctl,
  output scaled_t            scaled
);

  logic [17:0] angle_mag;
  logic [16:0] angle_sat;
  logic [9:0]  temp_sat;
  logic [16:0] value;
  div_sel_t    div_sel;
  logic        dp;
  logic        degree;
  logic [17:0] recip;
  logic [4:0]  shift;
  logic [34:0] prod;

  always_comb begin
    angle_mag = angle_centi[17] ? (~angle_centi + 18'd1) : angle_centi;
    angle_sat = (angle_mag > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : angle_mag[16:0];
    if (temp_deci[14]) begin
      temp_sat = '0;
    end else if (temp_deci[13:0] > {4'd0, TEMP_MAX}) begin
      temp_sat = TEMP_MAX;
    end else begin
      temp_sat = temp_deci[9:0];
    end

    dp = 1'b0;
    degree = 1'b0;
    div_sel = DIV_1;
    if (!ctl.mode) begin
      value = angle_sat;
      if (ctl.pos == POS_W'(NUM_DIGITS - 1)) begin
        degree = 1'b1;
      end else if (angle_sat < 17'd1000) begin
        case (ctl.pos)
          2'd0:    begin div_sel = DIV_100; dp = 1'b1; end
          2'd1:    div_sel = DIV_10;
          default: div_sel = DIV_1;
        endcase
      end else if (angle_sat < 17'd10000) begin
        case (ctl.pos)
          2'd0:    div_sel = DIV_1K;
          2'd1:    begin div_sel = DIV_100; dp = 1'b1; end
          default: div_sel = DIV_10;
        endcase
      end else begin
        case (ctl.pos)
          2'd0:    div_sel = DIV_10K;
          2'd1:    div_sel = DIV_1K;
          default: div_sel = DIV_100;
        endcase
      end
    end else begin
      value = {7'd0, temp_sat};
      case (ctl.pos)
        2'd1:    begin div_sel = DIV_10; dp = 1'b1; end
        2'd2:    div_sel = DIV_1;
        default: div_sel = DIV_100;
      endcase
    end

    case (div_sel)
      DIV_10:  begin recip = RECIP_10;  shift = SHIFT_10;  end
      DIV_100: begin recip = RECIP_100; shift = SHIFT_100; end
      DIV_1K:  begin recip = RECIP_1K;  shift = SHIFT_1K;  end
      DIV_10K: begin recip = RECIP_10K; shift = SHIFT_10K; end
      default: begin recip = 18'd1;     shift = 5'd0;      end
    endcase

    prod = 35'(value) * 35'(recip);
    scaled.quot = 17'(prod >> shift);
    scaled.dp = dp;
    scaled.degree = degree;
  end

endmodule

FILE: sv/seven_segment_scan_formatter_core.sv
// Top level of the four-digit seven-segment scan formatter.
//
//   channel  | dir | fields (low bit first)
//   s_*      | in  | angle_centi[17:0], temp_deci[32:18], zero pad to 40
//   m_*      | out | digit_enable[3:0], segments[10:4], decimal_point[11], glyph[15:12]
//   cfg_*    | in  | index 0 mode, 1 enable, 2 flash enable, 3 flash period
//
// One word per cycle while m_* is not stalled; a taken word is registered in stage 1,
// then stage 2, then on m_* in stage 3. Flash state advances when a word is taken, scan
// state when a shown word is taken; scaling and digit extraction run in stages 2 and 3.
// Each stage holds while the one after it is full and stalled; bubbles close up.
// rst clears control state and loads the register defaults.
`timescale 1ns / 1ps

module seven_segment_scan_formatter_core
  import sssf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // angle_centi, temp_deci
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // digit_enable, segments, decimal_point, glyph
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [1:0] {
    REG_VIEW_MODE      = 2'd0,
    REG_DISPLAY_ENABLE = 2'd1,
    REG_FLASH_ENABLE   = 2'd2,
    REG_BLINK_PERIOD   = 2'd3
  } reg_idx_t;

  logic             view_mode;
  logic             display_enable;
  logic             flash_enable;
  logic [15:0]      blink_period;
  logic [POS_W-1:0] angle_scan_pos;
  logic [POS_W-1:0] temp_scan_pos;
  logic [15:0]      tick_count;
  logic             blank_phase;

  logic             blank_phase_next;
  logic [15:0]      tick_count_next;
  logic [POS_W-1:0] angle_scan_pos_next;
  logic [POS_W-1:0] temp_scan_pos_next;
  logic [16:0]      tick_inc;
  logic [15:0]      period;
  logic [POS_W-1:0] temp_pos;
  ctl_t             ctl_in;
  logic             accept;

  logic        v1;
  logic [17:0] angle1;
  logic [14:0] temp1;
  ctl_t        ctl1;

  logic    v2;
  ctl_t    ctl2;
  scaled_t scaled;
  scaled_t scaled2;

  logic        rdy2;
  logic        rdy3;
  logic [34:0] prod10;
  logic [13:0] quot10;
  logic [16:0] rem;
  logic [3:0]  glyph;

  assign rdy3 = !m_tvalid || m_tready;
  assign rdy2 = !v2 || rdy3;
  assign s_tready = !v1 || rdy2;
  assign accept = s_tvalid && s_tready;

  always_comb begin
    period = (blink_period == 16'd0) ? 16'd1 : blink_period;
    if (flash_enable) begin
      blank_phase_next = (tick_count == 16'd0) ? !blank_phase : blank_phase;
    end else begin
      blank_phase_next = 1'b0;
    end
    tick_inc = {1'b0, tick_count} + 17'd1;
    tick_count_next = (tick_inc >= {1'b0, period}) ? 16'd0 : tick_inc[15:0];

    temp_pos = (temp_scan_pos > POS_W'(2)) ? '0 : temp_scan_pos;
    ctl_in.mode = view_mode;
    ctl_in.show = display_enable && !blank_phase_next;
    ctl_in.pos  = view_mode ? temp_pos : angle_scan_pos;

    angle_scan_pos_next = angle_scan_pos;
    temp_scan_pos_next  = temp_scan_pos;
    if (ctl_in.show) begin
      if (!view_mode) begin
        angle_scan_pos_next = angle_scan_pos + POS_W'(1);
      end else begin
        temp_scan_pos_next = (temp_pos >= POS_W'(2)) ? '0 : temp_pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      view_mode      <= 1'b0;
      display_enable <= 1'b0;
      flash_enable   <= 1'b0;
      blink_period   <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_VIEW_MODE:      view_mode      <= cfg_wdata[0];
        REG_DISPLAY_ENABLE: display_enable <= cfg_wdata[0];
        REG_FLASH_ENABLE:   flash_enable   <= cfg_wdata[0];
        REG_BLINK_PERIOD:   blink_period   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_scan_pos <= '0;
      temp_scan_pos  <= '0;
      tick_count     <= '0;
      blank_phase    <= 1'b0;
    end else if (accept) begin
      angle_scan_pos <= angle_scan_pos_next;
      temp_scan_pos  <= temp_scan_pos_next;
      tick_count     <= tick_count_next;
      blank_phase    <= blank_phase_next;
    end
  end

  // stage 1: input word and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
    if (accept) begin
      angle1 <= s_tdata[17:0];
      temp1  <= s_tdata[32:18];
      ctl1   <= ctl_in;
    end
  end

  sssf_scale u_scale (
    .angle_centi (angle1),
    .temp_deci   (temp1),
    .ctl         (ctl1),
    .scaled      (scaled)
  );

  // stage 2: scaled value
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      ctl2    <= ctl1;
      scaled2 <= scaled;
    end
  end

  always_comb begin
    prod10 = 35'(scaled2.quot) * 35'(RECIP_10);
    quot10 = prod10[34:21];
    rem    = scaled2.quot - ({quot10, 3'b000} + {2'b00, quot10, 1'b0});
    glyph  = scaled2.degree ? GLYPH_DEGREE : rem[3:0];
  end

  // stage 3: result word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy3) begin
      m_tvalid <= v2;
    end
    if (rdy3) begin
      if (ctl2.show) begin
        m_tdata <= {glyph, scaled2.dp, seg_code(glyph), 4'(4'b0001 << ctl2.pos)};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

FILE: sv/sssf_checker.sv
// Port-level checks on the result channel of the scan formatter, bound to the top level.
`timescale 1ns / 1ps

module sssf_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  a_digit_onehot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[3:0]))
    else $error("more than one digit selected");

  a_blank_dark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[3:0] == 4'd0) |-> (m_tdata[15:4] == 12'd0))
    else $error("blank word lights segments");

  a_degree_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[15:12] == 4'd10) |-> (m_tdata[3:0] == 4'b1000) && !m_tdata[11])
    else $error("degree sign off the last digit");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled word changed");

endmodule

bind seven_segment_scan_formatter_core sssf_checker u_sssf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
